// ----- rtl/pst_pkg.sv -----
`default_nettype none
package pst_pkg;

	localparam int SESSIONS    = 16;
	localparam int IDX_W       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd60;
	localparam logic [15:0] ID_EMPTY      = 16'd0;

	localparam logic KIND_PING    = 1'b0;
	localparam logic KIND_EXPIRED = 1'b1;

	typedef enum logic [1:0] {
		OP_PING  = 2'd0,
		OP_SWEEP = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_CREATED = 2'd1,
		ST_DROPPED = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_CLAIM,
		S_SWEEP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] first;
		logic [31:0] last;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} row_ctl_t;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic [15:0] tag;
		logic [31:0] first;
		logic [31:0] last;
		logic        fin;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/pst_cell.sv -----
`default_nettype none
module pst_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pst_pkg::row_ctl_t ctl,
	input  wire pst_pkg::entry_t   d,
	output pst_pkg::entry_t        q
);
	import pst_pkg::*;

	logic [15:0] id_q;
	logic [31:0] first_q;
	logic [31:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q   <= ID_EMPTY;
			last_q <= 32'd0;
		end else if (ctl.clear) begin
			id_q   <= ID_EMPTY;
			last_q <= 32'd0;
		end else if (ctl.shift) begin
			id_q   <= d.id;
			last_q <= d.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			first_q <= d.first;
		end
	end

	assign q = '{id: id_q, first: first_q, last: last_q};

endmodule
`default_nettype wire

// ----- rtl/pst_ctrl.sv -----
`default_nettype none
module pst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [15:0]       cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [15:0]       remote_id,
	input  wire logic              need_strong,
	input  wire logic              signal_strong,
	input  wire logic [31:0]       now_secs,
	input  wire pst_pkg::entry_t   head,
	output pst_pkg::entry_t        wb,
	output pst_pkg::row_ctl_t      ctl,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pst_pkg::result_t       out_res
);
	import pst_pkg::*;

	state_t            state_q, state_n;
	logic [15:0]       timeout_q;
	logic              tracking_q, tracking_n;
	logic [IDX_W-1:0]  cnt_q, cnt_n;
	logic [CNT_W-1:0]  n_q, n_n;
	logic              free_q, free_n;
	logic              pend_valid_q, pend_valid_n;
	result_t           pend_q, pend_n;
	logic [15:0]       id_q, id_n;
	logic [31:0]       now_q, now_n;
	logic              out_valid_q;
	result_t           out_q, out_d;
	logic              load_out;
	logic              out_free;
	logic              last_step;
	logic              head_exp;
	logic              head_free;
	logic              head_hit;
	logic              stall;
	logic [31:0]       age;

	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (cnt_q == IDX_W'(SESSIONS - 1));
	assign head_free = (head.id == ID_EMPTY);
	assign head_hit  = (head.id == id_q);
	assign age       = now_q - head.last;
	assign head_exp  = !head_free && (age > {16'd0, timeout_q})
		&& (n_q != CNT_W'(MAX_RESULTS));
	assign stall     = head_exp && pend_valid_q && !out_free;

	always_comb begin
		state_n      = state_q;
		tracking_n   = tracking_q;
		cnt_n        = cnt_q;
		n_n          = n_q;
		free_n       = free_q;
		pend_valid_n = pend_valid_q;
		pend_n       = pend_q;
		id_n         = id_q;
		now_n        = now_q;
		wb           = head;
		ctl          = '{shift: 1'b0, clear: 1'b0};
		load_out     = 1'b0;
		out_d        = pend_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					id_n         = remote_id;
					now_n        = now_secs;
					cnt_n        = '0;
					n_n          = '0;
					free_n       = 1'b0;
					pend_valid_n = 1'b0;
					unique case (op_t'(operation))
						OP_PING: begin
							if (!tracking_q || (need_strong && !signal_strong)
								|| remote_id == ID_EMPTY) begin
								pend_n = '{kind: KIND_PING, status: ST_IGNORED,
									tag: remote_id, first: 32'd0, last: 32'd0,
									fin: 1'b1};
								pend_valid_n = 1'b1;
								state_n      = S_DONE;
							end else begin
								state_n = S_MATCH;
							end
						end
						OP_SWEEP: state_n = S_SWEEP;
						OP_START: begin
							if (!tracking_q) begin
								ctl.clear  = 1'b1;
								tracking_n = 1'b1;
							end
						end
						OP_STOP: tracking_n = 1'b0;
						default: state_n = S_IDLE;
					endcase
				end
			end
			S_MATCH: begin
				ctl.shift = 1'b1;
				cnt_n     = cnt_q + 1'b1;
				if (head_hit) begin
					wb.last = now_q;
					pend_n  = '{kind: KIND_PING, status: ST_UPDATED, tag: id_q,
						first: head.first, last: now_q, fin: 1'b1};
					pend_valid_n = 1'b1;
				end
				if (head_free) begin
					free_n = 1'b1;
				end
				if (last_step) begin
					cnt_n = '0;
					if (head_hit || pend_valid_q) begin
						state_n = S_DONE;
					end else if (free_q || head_free) begin
						state_n = S_CLAIM;
					end else begin
						pend_n = '{kind: KIND_PING, status: ST_DROPPED, tag: id_q,
							first: 32'd0, last: 32'd0, fin: 1'b1};
						pend_valid_n = 1'b1;
						state_n      = S_DONE;
					end
				end
			end
			S_CLAIM: begin
				ctl.shift = 1'b1;
				cnt_n     = cnt_q + 1'b1;
				if (!pend_valid_q && head_free) begin
					wb     = '{id: id_q, first: now_q, last: now_q};
					pend_n = '{kind: KIND_PING, status: ST_CREATED, tag: id_q,
						first: now_q, last: now_q, fin: 1'b1};
					pend_valid_n = 1'b1;
				end
				if (last_step) begin
					cnt_n   = '0;
					state_n = S_DONE;
				end
			end
			S_SWEEP: begin
				if (!stall) begin
					ctl.shift = 1'b1;
					cnt_n     = cnt_q + 1'b1;
					if (head_exp) begin
						if (pend_valid_q) begin
							load_out  = 1'b1;
							out_d.fin = 1'b0;
						end
						pend_n = '{kind: KIND_EXPIRED, status: ST_UPDATED,
							tag: head.id, first: head.first, last: head.last,
							fin: 1'b1};
						pend_valid_n = 1'b1;
						n_n          = n_q + 1'b1;
						wb.id        = ID_EMPTY;
						wb.last      = 32'd0;
					end
					if (last_step) begin
						cnt_n   = '0;
						state_n = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!pend_valid_q) begin
					state_n = S_IDLE;
				end else if (out_free) begin
					load_out     = 1'b1;
					out_d.fin    = 1'b1;
					pend_valid_n = 1'b0;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			timeout_q    <= TIMEOUT_RESET;
			tracking_q   <= 1'b0;
			cnt_q        <= '0;
			n_q          <= '0;
			free_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_n;
			tracking_q   <= tracking_n;
			cnt_q        <= cnt_n;
			n_q          <= n_n;
			free_q       <= free_n;
			pend_valid_q <= pend_valid_n;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_n;
		id_q   <= id_n;
		now_q  <= now_n;
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

// ----- rtl/proximity_session_table.sv -----
// Start and stop finish in idle without a ring walk. An ignored ping goes straight from idle to the done
// state to give its result; any other ping walks the ring once to match, and again to claim a free slot.
// A sweep walks the ring once and is held while the output side is stalled with a record pending.
// No new request is accepted until the rotating session ring is through with the last one.
// Reset (arst_n, asynchronous, active low) empties every slot, stops tracking and sets
// the timeout to 60 seconds; no clearing pass is needed.
`default_nettype none
module proximity_session_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] remote_id,
	input  wire logic        need_strong,
	input  wire logic        signal_strong,
	input  wire logic [31:0] now_secs,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [1:0]       status,
	output logic [15:0]      tag_id,
	output logic [31:0]      first_seen,
	output logic [31:0]      last_seen,
	output logic             last_of_run
);
	import pst_pkg::*;

	entry_t   cell_q [SESSIONS];
	entry_t   wb;
	row_ctl_t ctl;
	result_t  res;

	for (genvar i = 0; i < SESSIONS; i++) begin : g_cell
		entry_t d;
		if (i == SESSIONS - 1) begin : g_tail
			assign d = wb;
		end else begin : g_mid
			assign d = cell_q[i + 1];
		end
		pst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	pst_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.remote_id     (remote_id),
		.need_strong   (need_strong),
		.signal_strong (signal_strong),
		.now_secs      (now_secs),
		.head          (cell_q[0]),
		.wb            (wb),
		.ctl           (ctl),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_res       (res)
	);

	assign kind        = res.kind;
	assign status      = res.status;
	assign tag_id      = res.tag;
	assign first_seen  = res.first;
	assign last_seen   = res.last;
	assign last_of_run = res.fin;

endmodule
`default_nettype wire

// ----- rtl/pst_checker.sv -----
`default_nettype none
module pst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  operation,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        kind,
	input wire logic [1:0]  status,
	input wire logic [15:0] tag_id,
	input wire logic [31:0] first_seen,
	input wire logic [31:0] last_seen,
	input wire logic        last_of_run
);
	import pst_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_id) && $stable(kind)
			&& $stable(last_seen))
		else $error("Result changed while stalled.");

	a_ctl_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_START || operation == OP_STOP)
			|=> in_ready)
		else $error("Start or stop did not finish in one cycle.");

	a_ping_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PING |-> last_of_run)
		else $error("Ping status not marked as final result.");

	a_expired_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EXPIRED |-> status == ST_UPDATED)
		else $error("Expired record carries a nonzero status.");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PING && (status == ST_DROPPED || status == ST_IGNORED)
			|-> first_seen == 32'd0 && last_seen == 32'd0)
		else $error("Rejected ping reports session times.");

endmodule

bind proximity_session_table pst_checker u_pst_checker (.*);
`default_nettype wire
